FILE: hw/rtl/flp_pkg.sv
// Package with the shared types and constants of the fixed length frame parser.
package flp_pkg;

  localparam int unsigned PAYLOAD_LEN = 16;
  localparam int unsigned CntW = $clog2(PAYLOAD_LEN + 1);

  localparam logic [7:0] PREAMBLE_A = 8'hFA;
  localparam logic [7:0] PREAMBLE_B = 8'hDE;

  typedef enum logic [1:0] {
    KIND_HUNT     = 2'd0,
    KIND_FUNCTION = 2'd1,
    KIND_PAYLOAD  = 2'd2,
    KIND_CHECKSUM = 2'd3
  } flp_kind_e;

  typedef enum logic [4:0] {
    ST_HUNT  = 5'b00001,
    ST_PRE2  = 5'b00010,
    ST_FUNC  = 5'b00100,
    ST_DATA  = 5'b01000,
    ST_CHECK = 5'b10000
  } flp_state_e;

  // Byte held in the input stage, with its valid flag.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } flp_byte_t;

  typedef struct packed {
    flp_kind_e  byte_kind;
    logic [7:0] function_code;
    logic [7:0] payload_byte;
    logic [3:0] payload_index;
    logic       packet_found;
    logic       checksum_bad;
    logic [7:0] checksum_computed;
  } flp_result_t;

endpackage

FILE: hw/rtl/flp_in_stage.sv
// Input register stage that holds one received byte until the parser takes it.
module flp_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       rx_byte_i,
  input  logic             advance_i,
  output flp_pkg::flp_byte_t byte_o
);
  import flp_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;

  // A held byte that cannot move on blocks the input.
  assign in_stall_o = valid_q & ~advance_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        data_d = rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign byte_o.valid = valid_q;
  assign byte_o.data  = data_q;

endmodule

FILE: hw/rtl/flp_core.sv
// Parser state and the single-pass logic that turns one byte into one result.
module flp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  flp_pkg::flp_byte_t   byte_i,
  input  logic                 advance_i,
  output flp_pkg::flp_result_t result_o
);
  import flp_pkg::*;

  flp_state_e      state_q, state_d;
  logic [7:0]      sum_q, sum_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      func_q, func_d;
  logic [7:0]      c;
  logic [7:0]      sum_add;
  logic [CntW-1:0] count_inc;
  logic [7:0]      count_ext;

  assign c         = byte_i.data;
  assign sum_add   = sum_q + c;
  assign count_inc = count_q + CntW'(1);
  assign count_ext = 8'(count_q);

  always_comb begin
    state_d  = state_q;
    sum_d    = sum_q;
    count_d  = count_q;
    func_d   = func_q;
    result_o = '0;
    case (state_q)
      ST_PRE2: begin
        state_d = (c == PREAMBLE_B) ? ST_FUNC : ST_HUNT;
      end
      ST_FUNC: begin
        func_d  = c;
        sum_d   = c;
        count_d = '0;
        state_d = ST_DATA;
        result_o.byte_kind         = KIND_FUNCTION;
        result_o.function_code     = c;
        result_o.checksum_computed = c;
      end
      ST_DATA: begin
        sum_d   = sum_add;
        count_d = count_inc;
        if (count_inc == CntW'(PAYLOAD_LEN)) begin
          state_d = ST_CHECK;
        end
        result_o.byte_kind         = KIND_PAYLOAD;
        result_o.function_code     = func_q;
        result_o.payload_byte      = c;
        result_o.payload_index     = count_ext[3:0];
        result_o.checksum_computed = sum_add;
      end
      ST_CHECK: begin
        state_d = ST_HUNT;
        result_o.byte_kind         = KIND_CHECKSUM;
        result_o.function_code     = func_q;
        result_o.packet_found      = 1'b1;
        result_o.checksum_bad      = (sum_q != c);
        result_o.checksum_computed = sum_q;
      end
      default: begin
        state_d = (c == PREAMBLE_A) ? ST_PRE2 : ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
      sum_q   <= '0;
      count_q <= '0;
      func_q  <= '0;
    end else if (advance_i) begin
      state_q <= state_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      func_q  <= func_d;
    end
  end

endmodule

FILE: hw/rtl/flp_out_stage.sv
// Result register that holds one result item until the receiver takes it.
module flp_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  flp_pkg::flp_result_t result_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output flp_pkg::flp_result_t result_o
);
  import flp_pkg::*;

  logic        valid_q, valid_d;
  flp_result_t result_q, result_d;

  always_comb begin
    valid_d  = valid_q;
    result_d = result_q;
    if (load_i) begin
      valid_d  = 1'b1;
      result_d = result_i;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

FILE: hw/rtl/fixed_length_frame_parser.sv
// Byte-serial frame parser: it hunts for the preamble 0xFA 0xDE, then takes a function
// byte, PAYLOAD_LEN payload bytes and a checksum byte, and gives one result item for
// every received byte. The checksum is the 8-bit wrapping sum of the function and
// payload bytes, and its error flag applies to the current packet only. A byte
// passes from input to output through the input register, then the result register,
// and a new byte is accepted every cycle while the output is not stalled.
module fixed_length_frame_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] byte_kind_o,
  output logic [7:0] function_code_o,
  output logic [7:0] payload_byte_o,
  output logic [3:0] payload_index_o,
  output logic       packet_found_o,
  output logic       checksum_bad_o,
  output logic [7:0] checksum_computed_o
);
  import flp_pkg::*;

  flp_byte_t   in_byte;
  flp_result_t core_result;
  flp_result_t out_result;
  logic        advance;

  // The held byte moves on when the result register is empty or being emptied.
  assign advance = in_byte.valid & ~(out_valid_o & out_stall_i);

  flp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .byte_o     (in_byte)
  );

  flp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (in_byte),
    .advance_i (advance),
    .result_o  (core_result)
  );

  flp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (core_result),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (out_result)
  );

  assign byte_kind_o         = out_result.byte_kind;
  assign function_code_o     = out_result.function_code;
  assign payload_byte_o      = out_result.payload_byte;
  assign payload_index_o     = out_result.payload_index;
  assign packet_found_o      = out_result.packet_found;
  assign checksum_bad_o      = out_result.checksum_bad;
  assign checksum_computed_o = out_result.checksum_computed;

endmodule
